[rtl/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and constants of the k-way merge by position block
// Widths, status and operation codes, heap entry type, heap order and the
// command and status groups passed between controller and datapath.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int MAX_STREAMS = 16;
  localparam int IDX_W       = $clog2(MAX_STREAMS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int WORD_W      = 32;
  localparam int KEY_W       = 2 * WORD_W;
  localparam int CFG_IDX_W   = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_COUNT    = 1'd1;

  // Configuration reset values.
  localparam logic [CNT_W-1:0]  STREAM_COUNT_RST = CNT_W'(2);
  localparam logic [WORD_W-1:0] REF_COUNT_RST    = WORD_W'(1);

  // Input operation codes.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_REFILL = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_EMIT    = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_CORRUPT = 2'd2;

  // One heap slot: an invalid slot stands for an exhausted stream.
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [IDX_W-1:0]  src;
    logic [WORD_W-1:0] pay;
  } heap_ent_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       in_ready;
    logic       load_write;
    logic       latch_size;
    logic       x_refill;
    logic       rd_build;
    logic       x_from_rd;
    logic       rd_children;
    logic       write_x;
    logic       cmp_step;
    logic       b_dec;
    logic       rd_root;
    logic       set_root_src;
    logic       set_fault;
    logic       out_load;
    logic [1:0] out_kind;
  } kwm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic op;
    logic exh;
    logic st_ok;
    logic all_loaded;
    logic corrupt;
    logic small_heap;
    logic has_left;
    logic child_wins;
    logic build_last;
    logic root_valid;
    logic out_free;
  } kwm_stat_t;

  // Strict heap order: valid before invalid, then key, then source stream.
  function automatic logic slot_less(heap_ent_t a, heap_ent_t b);
    logic r;
    if (a.valid != b.valid) begin
      r = a.valid;
    end else if (a.valid && (a.key != b.key)) begin
      r = a.key < b.key;
    end else begin
      r = a.src < b.src;
    end
    return r;
  endfunction

endpackage

[rtl/kwm_req_if.sv]
// ----------------------------------------------------------------------------
// kwm_req_if: input item channel
// Valid/ready channel carrying one load or refill item.
// ----------------------------------------------------------------------------
interface kwm_req_if;
  import kwm_pkg::*;

  logic              valid;
  logic              ready;
  logic              operation;
  logic [IDX_W-1:0]  stream;
  logic              exhausted;
  logic [WORD_W-1:0] seq_id;
  logic [WORD_W-1:0] position;
  logic [WORD_W-1:0] record_tag;

  modport source (
    output valid, operation, stream, exhausted, seq_id, position, record_tag,
    input  ready
  );

  modport sink (
    input  valid, operation, stream, exhausted, seq_id, position, record_tag,
    output ready
  );
endinterface

[rtl/kwm_rsp_if.sv]
// ----------------------------------------------------------------------------
// kwm_rsp_if: result item channel
// Valid/ready channel carrying one merge result.
// ----------------------------------------------------------------------------
interface kwm_rsp_if;
  import kwm_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [WORD_W-1:0] out_seq_id;
  logic [WORD_W-1:0] out_position;
  logic [WORD_W-1:0] out_tag;
  logic [IDX_W-1:0]  refill_stream;

  modport source (
    output valid, status, out_seq_id, out_position, out_tag, refill_stream,
    input  ready
  );

  modport sink (
    input  valid, status, out_seq_id, out_position, out_tag, refill_stream,
    output ready
  );
endinterface

[rtl/kwm_cfg_if.sv]
// ----------------------------------------------------------------------------
// kwm_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface kwm_cfg_if;
  import kwm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/kwm_ctrl.sv]
// ----------------------------------------------------------------------------
// kwm_ctrl: merge controller
// Sequences item decode, heap build, sift-down steps, root emit and result
// hand-off, and keeps the merge phase.
// ----------------------------------------------------------------------------
module kwm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  kwm_pkg::kwm_stat_t stat,
  output kwm_pkg::kwm_cmd_t  cmd
);
  import kwm_pkg::*;

  // Merge phases.
  localparam logic [1:0] PH_LOADING = 2'd0;
  localparam logic [1:0] PH_MERGING = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;
  localparam logic [1:0] PH_ERROR   = 2'd3;

  // Controller states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_BUILD_RD = 4'd2;
  localparam logic [3:0] S_BUILD_LD = 4'd3;
  localparam logic [3:0] S_SIFT_RD  = 4'd4;
  localparam logic [3:0] S_SIFT_CMP = 4'd5;
  localparam logic [3:0] S_SIFT_END = 4'd6;
  localparam logic [3:0] S_EMIT_RD  = 4'd7;
  localparam logic [3:0] S_EMIT     = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;

  logic [3:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic [1:0] kind, kind_next;
  logic       building, building_next;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_LOADING;
      kind     <= ST_EMIT;
      building <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      kind     <= kind_next;
      building <= building_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    phase_next    = phase;
    kind_next     = kind;
    building_next = building;
    cmd           = '0;
    cmd.out_kind  = kind;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (phase)
          PH_DONE: begin
            kind_next  = ST_DONE;
            state_next = S_FIN;
          end
          PH_ERROR: begin
            kind_next  = ST_CORRUPT;
            state_next = S_FIN;
          end
          PH_LOADING: begin
            if ((stat.op != OP_LOAD) || !stat.st_ok) begin
              state_next = S_IDLE;
            end else begin
              cmd.load_write = 1'b1;
              if (stat.all_loaded) begin
                cmd.latch_size = 1'b1;
                phase_next     = PH_MERGING;
                if (stat.small_heap) begin
                  state_next = S_EMIT_RD;
                end else begin
                  building_next = 1'b1;
                  state_next    = S_BUILD_RD;
                end
              end else begin
                state_next = S_IDLE;
              end
            end
          end
          default: begin
            // Merging: only a refill does anything.
            if (stat.op != OP_REFILL) begin
              state_next = S_IDLE;
            end else if (!stat.exh && stat.corrupt) begin
              cmd.set_fault = 1'b1;
              phase_next    = PH_ERROR;
              kind_next     = ST_CORRUPT;
              state_next    = S_FIN;
            end else begin
              cmd.x_refill = 1'b1;
              state_next   = S_SIFT_RD;
            end
          end
        endcase
      end
      S_BUILD_RD: begin
        cmd.rd_build = 1'b1;
        state_next   = S_BUILD_LD;
      end
      S_BUILD_LD: begin
        cmd.x_from_rd = 1'b1;
        state_next    = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        if (stat.has_left) begin
          cmd.rd_children = 1'b1;
          state_next      = S_SIFT_CMP;
        end else begin
          cmd.write_x = 1'b1;
          state_next  = S_SIFT_END;
        end
      end
      S_SIFT_CMP: begin
        cmd.cmp_step = 1'b1;
        state_next   = stat.child_wins ? S_SIFT_RD : S_SIFT_END;
      end
      S_SIFT_END: begin
        if (building && !stat.build_last) begin
          cmd.b_dec  = 1'b1;
          state_next = S_BUILD_RD;
        end else begin
          building_next = 1'b0;
          state_next    = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        cmd.rd_root = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        cmd.set_root_src = 1'b1;
        if (stat.root_valid) begin
          kind_next = ST_EMIT;
        end else begin
          kind_next  = ST_DONE;
          phase_next = PH_DONE;
        end
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/kwm_dpath.sv]
// ----------------------------------------------------------------------------
// kwm_dpath: merge datapath
// Holds configuration, the captured item, the heap memory, the sifting
// element, loaded flags and the result register.
// ----------------------------------------------------------------------------
module kwm_dpath (
  input  logic               clk,
  input  logic               rst,
  kwm_req_if.sink            req,
  kwm_rsp_if.source          rsp,
  kwm_cfg_if.sink            cfg,
  input  kwm_pkg::kwm_cmd_t  cmd,
  output kwm_pkg::kwm_stat_t stat
);
  import kwm_pkg::*;

  logic [CNT_W-1:0]  stream_count;
  logic [WORD_W-1:0] ref_count;

  logic              cap_op;
  logic [IDX_W-1:0]  cap_stream;
  logic              cap_exh;
  logic [WORD_W-1:0] cap_seq;
  logic [WORD_W-1:0] cap_pos;
  logic [WORD_W-1:0] cap_tag;

  heap_ent_t         mem [MAX_STREAMS];
  heap_ent_t         rd_a, rd_b;
  heap_ent_t         x;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  b_idx;
  logic [CNT_W-1:0]  heap_size;
  logic [IDX_W-1:0]  root_src;
  logic [IDX_W-1:0]  fault_src;
  logic [MAX_STREAMS-1:0] loaded;

  logic              out_valid;
  logic [1:0]        out_status;
  logic [WORD_W-1:0] out_seq;
  logic [WORD_W-1:0] out_pos;
  logic [WORD_W-1:0] out_tag;
  logic [IDX_W-1:0]  out_src;

  logic [CNT_W-1:0]  n_eff;
  logic              all_loaded;
  logic [IDX_W+1:0]  l_pos, r_pos, size_ext;
  logic              has_right;
  logic              pick_l, pick_r, r_beats;
  heap_ent_t         winner;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  heap_ent_t         wdata;
  logic              re_a;
  logic [IDX_W-1:0]  addr_a;

  // Configuration writes; the port never stalls.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_count <= STREAM_COUNT_RST;
      ref_count    <= REF_COUNT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_STREAM_COUNT: stream_count <= cfg.data[CNT_W-1:0];
        REG_REF_COUNT:    ref_count    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Effective stream count: zero acts as one, large values saturate.
  always_comb begin
    if (stream_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (stream_count > CNT_W'(MAX_STREAMS)) begin
      n_eff = CNT_W'(MAX_STREAMS);
    end else begin
      n_eff = stream_count;
    end
  end

  // Input capture on each transfer.
  assign req.ready = cmd.in_ready;

  always_ff @(posedge clk) begin
    if (cmd.in_ready && req.valid) begin
      cap_op     <= req.operation;
      cap_stream <= req.stream;
      cap_exh    <= req.exhausted;
      cap_seq    <= req.seq_id;
      cap_pos    <= req.position;
      cap_tag    <= req.record_tag;
    end
  end

  // Loaded flags, counting the stream being loaded now.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (cmd.load_write) begin
      loaded[cap_stream] <= 1'b1;
    end
  end

  always_comb begin
    all_loaded = 1'b1;
    for (int i = 0; i < MAX_STREAMS; i++) begin
      if ((CNT_W'(i) < n_eff) && !loaded[i] && (cap_stream != IDX_W'(i))) begin
        all_loaded = 1'b0;
      end
    end
  end

  // Child positions of the current sift index.
  assign l_pos     = {1'b0, idx, 1'b1};
  assign r_pos     = l_pos + 1'b1;
  assign size_ext  = {1'b0, heap_size};
  assign has_right = r_pos < size_ext;

  // Three-way minimum of sifting element and children, compared in parallel.
  assign pick_l  = slot_less(rd_a, x);
  assign r_beats = pick_l ? slot_less(rd_b, rd_a) : slot_less(rd_b, x);
  assign pick_r  = has_right && r_beats;
  assign winner  = pick_r ? rd_b : (pick_l ? rd_a : x);

  // Heap memory write port.
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = x;
    if (cmd.load_write) begin
      we    = 1'b1;
      waddr = cap_stream;
      wdata = '{valid: !cap_exh, key: {cap_seq, cap_pos}, src: cap_stream, pay: cap_tag};
    end else if (cmd.write_x) begin
      we = 1'b1;
    end else if (cmd.cmp_step) begin
      we    = 1'b1;
      wdata = winner;
    end
  end

  // Heap memory read port A address.
  always_comb begin
    re_a   = cmd.rd_build || cmd.rd_children || cmd.rd_root;
    addr_a = '0;
    if (cmd.rd_build) begin
      addr_a = b_idx;
    end else if (cmd.rd_children) begin
      addr_a = l_pos[IDX_W-1:0];
    end
  end

  // Heap memory with registered reads.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re_a) rd_a <= mem[addr_a];
    if (cmd.rd_children) rd_b <= mem[r_pos[IDX_W-1:0]];
  end

  // Sifting element, sift index and build index.
  always_ff @(posedge clk) begin
    if (cmd.latch_size) begin
      heap_size <= n_eff;
      b_idx     <= n_eff[CNT_W-1:1] - 1'b1;
    end else if (cmd.b_dec) begin
      b_idx <= b_idx - 1'b1;
    end
    if (cmd.x_refill) begin
      x   <= '{valid: !cap_exh, key: {cap_seq, cap_pos}, src: root_src, pay: cap_tag};
      idx <= '0;
    end else if (cmd.x_from_rd) begin
      x   <= rd_a;
      idx <= b_idx;
    end else if (cmd.cmp_step && (pick_l || pick_r)) begin
      idx <= pick_r ? r_pos[IDX_W-1:0] : l_pos[IDX_W-1:0];
    end
    if (cmd.set_root_src) root_src  <= rd_a.src;
    if (cmd.set_fault)    fault_src <= root_src;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_kind;
      out_seq    <= '0;
      out_pos    <= '0;
      out_tag    <= '0;
      out_src    <= '0;
      case (cmd.out_kind)
        ST_EMIT: begin
          out_seq <= rd_a.key[KEY_W-1:WORD_W];
          out_pos <= rd_a.key[WORD_W-1:0];
          out_tag <= rd_a.pay;
          out_src <= rd_a.src;
        end
        ST_CORRUPT: out_src <= fault_src;
        default: ;
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.out_seq_id    = out_seq;
  assign rsp.out_position  = out_pos;
  assign rsp.out_tag       = out_tag;
  assign rsp.refill_stream = out_src;

  // Status toward the controller.
  always_comb begin
    stat            = '0;
    stat.in_valid   = req.valid;
    stat.op         = cap_op;
    stat.exh        = cap_exh;
    stat.st_ok      = {1'b0, cap_stream} < n_eff;
    stat.all_loaded = all_loaded;
    stat.corrupt    = cap_seq >= ref_count;
    stat.small_heap = n_eff < CNT_W'(2);
    stat.has_left   = l_pos < size_ext;
    stat.child_wins = pick_l || pick_r;
    stat.build_last = b_idx == '0;
    stat.root_valid = rd_a.valid;
    stat.out_free   = !out_valid || rsp.ready;
  end

endmodule

[rtl/k_way_merge_by_position_core.sv]
// One item at a time; a load that completes nothing passes through decode and frees the input
// again on the return to idle. After decode, a refill sifts down from the root, each heap level
// a child read from the registered heap memory and a compare, then the root read and hand-off.
// The last load builds the heap: n/2 sift-downs, from the last parent index down to the root.
// Synchronous reset returns to the loading phase, clears loaded flags and the result valid
// flag and restores configuration defaults; the heap memory is not cleared.
// ----------------------------------------------------------------------------
// k_way_merge_by_position_core: k-way merge of position-sorted streams
// Min-heap merge of stream heads keyed by sequence id and position, with a
// controller sequencing a datapath that holds the heap memory.
// ----------------------------------------------------------------------------
module k_way_merge_by_position_core (
  input  logic      clk,
  input  logic      rst,
  kwm_req_if.sink   req,
  kwm_rsp_if.source rsp,
  kwm_cfg_if.sink   cfg
);
  import kwm_pkg::*;

  kwm_cmd_t  cmd;
  kwm_stat_t stat;

  // Sequencer.
  kwm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Heap storage, compare and result logic.
  kwm_dpath u_dpath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cfg  (cfg),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule
